@@ design/tama_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tama_pkg
// Shared types and constants for the three-axis moving-average filter.
// ----------------------------------------------------------------------------
package tama_pkg;

    localparam int SAMPLE_W    = 16;   // Q3.12 acceleration, per axis
    localparam int COUNT_OUT_W = 6;    // width of samples_averaged
    localparam int AXES        = 3;

    typedef logic signed [SAMPLE_W-1:0] axis_t;

    // One ring entry: all three axes side by side
    typedef struct packed {
        axis_t x;
        axis_t y;
        axis_t z;
    } tama_sample_t;

    localparam int SAMPLE_WORD_W = $bits(tama_sample_t);

endpackage
`default_nettype wire

@@ design/tama_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tama_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module tama_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ design/three_axis_moving_average.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_moving_average
// Boxcar moving average over the last WINDOW accelerometer samples, per axis.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   ------------------------------------
//  sample    sample_valid / sample_ready  sample_x, sample_y, sample_z
//  mean      mean_valid / mean_ready      mean_x, mean_y, mean_z,
//                                         samples_averaged
//
//  Flow   : each item passes the ring memory read (accept cycle), the
//           read-modify-write of the running sums (update cycle) and the
//           divide cycle, which loads the mean register and mean_valid;
//           while the mean side keeps up, the divide cycle of one item
//           overlaps the accept cycle of the next.
//  Reset  : sums, ring pointer and fill count clear at once; the ring memory
//           itself is not cleared (no sweep). Until the fill count reaches
//           WINDOW, the entry being replaced is known unwritten and reads
//           as zero.
//  Stalls : a result held by mean_ready low parks the divide cycle, and
//           sample_ready stays low until the mean register frees up.
// ----------------------------------------------------------------------------
module three_axis_moving_average
    import tama_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample_x,
    input  wire logic signed [SAMPLE_W-1:0] sample_y,
    input  wire logic signed [SAMPLE_W-1:0] sample_z,

    output logic                        mean_valid,
    input  wire logic                   mean_ready,
    output logic signed [SAMPLE_W-1:0]  mean_x,
    output logic signed [SAMPLE_W-1:0]  mean_y,
    output logic signed [SAMPLE_W-1:0]  mean_z,
    output logic [COUNT_OUT_W-1:0]      samples_averaged
);

    // ------------------------------------------------------------------
    // Sizes
    // ------------------------------------------------------------------
    localparam int AW = $clog2(WINDOW);       // ring index
    localparam int CW = $clog2(WINDOW + 1);   // fill count, 0..WINDOW
    localparam int SW = SAMPLE_W + AW;        // exact running sum
    // Reciprocal scaling: quotient is exact for |sum| < 2^SW and divisor
    // up to 2^AW when the shift is SW + AW.
    localparam int K  = SW + AW;
    localparam int MW = K + 1;
    localparam int PW = SW + MW;

    // State codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;

    // ------------------------------------------------------------------
    // Reciprocal table: recip_tab[d] = ceil(2^K / d); entry 0 is unused
    // ------------------------------------------------------------------
    logic [MW-1:0] recip_tab [WINDOW+1];

    for (genvar g = 0; g <= WINDOW; g++)
    begin : g_recip
        localparam longint unsigned DIV   = (g == 0) ? 1 : g;
        localparam longint unsigned RECIP = ((64'd1 << K) + DIV - 64'd1) / DIV;
        assign recip_tab[g] = MW'(RECIP);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]               state_reg, state_next;
    tama_sample_t             samp_reg;
    logic [AW-1:0]            pos_reg;
    logic [CW-1:0]            count_reg;
    logic signed [SW-1:0]     sum_reg [AXES];
    logic signed [SW-1:0]     sum_next [AXES];
    logic                     mean_valid_reg;
    logic signed [SAMPLE_W-1:0] mean_reg [AXES];
    logic signed [SAMPLE_W-1:0] mean_next [AXES];
    logic [COUNT_OUT_W-1:0]   count_out_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic accept;
    logic div_done;     // divide cycle can hand its result to the mean reg
    logic ring_full;

    assign div_done     = (state_reg == ST_DIVIDE) && (!mean_valid_reg || mean_ready);
    assign sample_ready = (state_reg == ST_IDLE) || div_done;
    assign accept       = sample_valid && sample_ready;
    assign ring_full    = (count_reg == CW'(WINDOW));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = sample_valid ? ST_UPDATE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Ring memory: read the slot being replaced on accept, write the new
    // sample back during the update cycle.
    // ------------------------------------------------------------------
    tama_sample_t rd_word;
    logic         ram_wr_en;

    assign ram_wr_en = (state_reg == ST_UPDATE);

    tama_ram #(
        .WIDTH (SAMPLE_WORD_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (samp_reg),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (rd_word)
    );

    // ------------------------------------------------------------------
    // Update: sum - oldest + newest. Before the ring has filled, the slot
    // at pos_reg has never been written and stands for zero.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] old_ax  [AXES];
    logic signed [SAMPLE_W-1:0] samp_ax [AXES];

    always_comb
    begin
        samp_ax[0] = samp_reg.x;
        samp_ax[1] = samp_reg.y;
        samp_ax[2] = samp_reg.z;
        old_ax[0]  = ring_full ? rd_word.x : '0;
        old_ax[1]  = ring_full ? rd_word.y : '0;
        old_ax[2]  = ring_full ? rd_word.z : '0;
        for (int i = 0; i < AXES; i++)
        begin
            sum_next[i] = sum_reg[i] - SW'(old_ax[i]) + SW'(samp_ax[i]);
        end
    end

    // ------------------------------------------------------------------
    // Divide: |sum| * ceil(2^K / count) >> K, then restore the sign, which
    // truncates toward zero.
    // ------------------------------------------------------------------
    logic [MW-1:0] recip;

    assign recip = recip_tab[count_reg];

    always_comb
    begin
        logic          neg;
        logic [SW-1:0] mag;
        logic [PW-1:0] prod;
        logic [SAMPLE_W-1:0] quo;
        for (int i = 0; i < AXES; i++)
        begin
            neg  = sum_reg[i][SW-1];
            mag  = neg ? SW'(-sum_reg[i]) : SW'(sum_reg[i]);
            prod = PW'(mag) * PW'(recip);
            quo  = prod[K +: SAMPLE_W];
            mean_next[i] = neg ? SAMPLE_W'(-quo) : SAMPLE_W'(quo);
        end
    end

    // ------------------------------------------------------------------
    // Sequential
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            count_reg      <= '0;
            mean_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    sum_reg[i] <= sum_next[i];
                end
                pos_reg <= (pos_reg == AW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                if (!ring_full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (div_done)
            begin
                mean_valid_reg <= 1'b1;
            end
            else if (mean_ready)
            begin
                mean_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg.x <= sample_x;
            samp_reg.y <= sample_y;
            samp_reg.z <= sample_z;
        end
        if (div_done)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                mean_reg[i] <= mean_next[i];
            end
            count_out_reg <= COUNT_OUT_W'(count_reg);
        end
    end

    assign mean_valid       = mean_valid_reg;
    assign mean_x           = mean_reg[0];
    assign mean_y           = mean_reg[1];
    assign mean_z           = mean_reg[2];
    assign samples_averaged = count_out_reg;

endmodule
`default_nettype wire

@@ design/tama_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tama_checker
// Port-level checks for the three-axis moving-average filter.
// ----------------------------------------------------------------------------
module tama_checker
    import tama_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       sample_valid,
    input wire logic                       sample_ready,
    input wire logic                       mean_valid,
    input wire logic                       mean_ready,
    input wire logic signed [SAMPLE_W-1:0] mean_x,
    input wire logic signed [SAMPLE_W-1:0] mean_y,
    input wire logic signed [SAMPLE_W-1:0] mean_z,
    input wire logic [COUNT_OUT_W-1:0]     samples_averaged
);

    logic                   in_acc;
    logic                   out_acc;
    logic [1:0]             pending_reg;
    logic                   seen_reg;
    logic [COUNT_OUT_W-1:0] last_cnt_reg;

    assign in_acc  = sample_valid && sample_ready;
    assign out_acc = mean_valid && mean_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            seen_reg     <= 1'b0;
            last_cnt_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_acc) - 2'(out_acc);
            if (out_acc)
            begin
                seen_reg     <= 1'b1;
                last_cnt_reg <= samples_averaged;
            end
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mean_valid && !mean_ready |=> mean_valid && $stable(mean_x)
            && $stable(mean_y) && $stable(mean_z) && $stable(samples_averaged))
        else $error("stalled mean changed");

    // No result without an item behind it, and at most two items in flight
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (mean_valid |-> pending_reg != 2'd0) and (pending_reg <= 2'd2))
        else $error("results and items out of balance");

    // Count starts at 1 and climbs by one until it sticks at WINDOW
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        mean_valid |-> (!seen_reg && samples_averaged == COUNT_OUT_W'(1))
            || (seen_reg && samples_averaged == last_cnt_reg + 1'b1)
            || (seen_reg && last_cnt_reg == COUNT_OUT_W'(WINDOW)
                && samples_averaged == last_cnt_reg))
        else $error("samples_averaged out of sequence");

    // Count is never zero unless the 6-bit field wraps
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mean_valid |-> (WINDOW >= 64) || (samples_averaged != '0))
        else $error("zero samples_averaged");

endmodule

bind three_axis_moving_average tama_checker #(
    .WINDOW (WINDOW)
) u_tama_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .mean_valid       (mean_valid),
    .mean_ready       (mean_ready),
    .mean_x           (mean_x),
    .mean_y           (mean_y),
    .mean_z           (mean_z),
    .samples_averaged (samples_averaged)
);
`default_nettype wire
